// ----- src/multi_timer_scheduler_core_assert.svh -----
// ----------------------------------------------------------------------------
// Multi-timer scheduler assertion macros
// Concurrent checks that can be compiled out with ASSERT_OFF.
// ----------------------------------------------------------------------------
`ifndef MULTI_TIMER_SCHEDULER_CORE_ASSERT_SVH
`define MULTI_TIMER_SCHEDULER_CORE_ASSERT_SVH
`ifndef ASSERT_OFF
`define MTS_ASSERT_IMPL(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("mts assertion failed");
`define MTS_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("mts assertion failed");
`else
`define MTS_ASSERT_IMPL(label, clk, rst, ante, cons)
`define MTS_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

// ----- src/mts_pkg.sv -----
// ----------------------------------------------------------------------------
// Multi-timer scheduler package
// Payload types, codes and controller/datapath handshake types.
// ----------------------------------------------------------------------------
package mts_pkg;

  localparam int NUM_TIMERS_DEF = 8;
  localparam int MAX_STEPS      = 7;
  localparam int ACC_W          = 40;
  localparam int CFG_IDX_W      = 1;

  localparam logic [2:0] ACT_SCHEDULE   = 3'd0;
  localparam logic [2:0] ACT_CANCEL     = 3'd1;
  localparam logic [2:0] ACT_CANCEL_ALL = 3'd2;
  localparam logic [2:0] ACT_SET_PAUSE  = 3'd3;
  localparam logic [2:0] ACT_QUERY      = 3'd4;
  localparam logic [2:0] ACT_ADVANCE    = 3'd5;

  localparam logic [1:0] KIND_DELIVERY = 2'd0;
  localparam logic [1:0] KIND_STATUS   = 2'd1;
  localparam logic [1:0] KIND_FINISHED = 2'd2;

  localparam logic [1:0] ST_OK          = 2'd0;
  localparam logic [1:0] ST_BAD_HANDLE  = 2'd1;
  localparam logic [1:0] ST_SLOT_IN_USE = 2'd2;
  localparam logic [1:0] ST_BAD_ARG     = 2'd3;

  localparam logic [CFG_IDX_W-1:0] CFG_TIME_SCALE = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_STEPS  = 1'd1;

  localparam logic [15:0] TIME_SCALE_RST = 16'd256;
  localparam logic [2:0]  MAX_STEPS_RST  = 3'd4;

  typedef struct packed {
    logic [2:0]  action;
    logic [2:0]  timer_slot;
    logic [31:0] interval;
    logic [31:0] first_delay;
    logic        delay_given;
    logic [31:0] repeat_count;
    logic        repeat_forever;
    logic        ignores_scale;
    logic        paused;
    logic [31:0] delta;
  } in_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [2:0]  slot;
    logic [31:0] iteration;
    logic        retired;
    logic [1:0]  status;
    logic [31:0] time_left;
    logic        is_paused;
    logic        is_active;
    logic [3:0]  active_count;
    logic [63:0] discarded_total;
    logic        last;
  } out_t;

  typedef struct packed {
    logic [CFG_IDX_W-1:0] index;
    logic [15:0]          value;
  } cfg_t;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_CAPTURE,
    OP_EXEC,
    OP_EMIT_STATUS,
    OP_SCALE,
    OP_SLOT_LOAD,
    OP_STEP,
    OP_WRITEBACK,
    OP_DIV_STEP,
    OP_DIV_DONE,
    OP_NEXT_SLOT,
    OP_EMIT_DELIV,
    OP_EMIT_FIN
  } dp_op_t;

  typedef struct packed {
    logic is_advance;
    logic out_free;
    logic slot_run;
    logic step_stop;
    logic need_div;
    logic div_done;
    logic last_slot;
    logic buf_empty;
    logic buf_end;
  } dp_status_t;

endpackage

// ----- src/mts_channels.sv -----
// ----------------------------------------------------------------------------
// Multi-timer scheduler channels
// Valid/ready channels for requests, results and configuration writes.
// ----------------------------------------------------------------------------
interface mts_req_if;
  logic          valid;
  logic          ready;
  mts_pkg::in_t  data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface mts_rsp_if;
  logic          valid;
  logic          ready;
  mts_pkg::out_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface mts_cfg_if;
  logic          valid;
  logic          ready;
  mts_pkg::cfg_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ----- src/mts_ctrl.sv -----
// ----------------------------------------------------------------------------
// Multi-timer scheduler controller
// Sequences commands, the advance slot walk and result emission.
// ----------------------------------------------------------------------------
module mts_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  mts_pkg::dp_status_t st,
  output mts_pkg::dp_op_t     op
);

  typedef enum logic [3:0] {
    S_IDLE, S_DISP, S_EXEC, S_STATUS, S_SCALE, S_LOAD, S_STEP,
    S_WB, S_DIV, S_DIVEND, S_NEXT, S_RD, S_EMIT, S_FIN
  } state_t;

  state_t state, state_next;

  assign in_ready = (state == S_IDLE);

  always_comb begin
    state_next = state;
    op         = mts_pkg::OP_NONE;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          op         = mts_pkg::OP_CAPTURE;
          state_next = S_DISP;
        end
      end
      S_DISP:   state_next = st.is_advance ? S_SCALE : S_EXEC;
      S_EXEC: begin
        op         = mts_pkg::OP_EXEC;
        state_next = S_STATUS;
      end
      S_STATUS: begin
        if (st.out_free) begin
          op         = mts_pkg::OP_EMIT_STATUS;
          state_next = S_IDLE;
        end
      end
      S_SCALE: begin
        op         = mts_pkg::OP_SCALE;
        state_next = S_LOAD;
      end
      S_LOAD: begin
        op         = mts_pkg::OP_SLOT_LOAD;
        state_next = st.slot_run ? S_STEP : S_NEXT;
      end
      S_STEP: begin
        op = mts_pkg::OP_STEP;
        if (st.step_stop) state_next = S_WB;
      end
      S_WB: begin
        op         = mts_pkg::OP_WRITEBACK;
        state_next = st.need_div ? S_DIV : S_NEXT;
      end
      S_DIV: begin
        op = mts_pkg::OP_DIV_STEP;
        if (st.div_done) state_next = S_DIVEND;
      end
      S_DIVEND: begin
        op         = mts_pkg::OP_DIV_DONE;
        state_next = S_NEXT;
      end
      S_NEXT: begin
        op = mts_pkg::OP_NEXT_SLOT;
        priority if (!st.last_slot) state_next = S_LOAD;
        else if (st.buf_empty)      state_next = S_FIN;
        else                        state_next = S_RD;
      end
      S_RD:     state_next = S_EMIT;
      S_EMIT: begin
        if (st.out_free) begin
          op         = mts_pkg::OP_EMIT_DELIV;
          state_next = st.buf_end ? S_FIN : S_RD;
        end
      end
      S_FIN: begin
        if (st.out_free) begin
          op         = mts_pkg::OP_EMIT_FIN;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

// ----- src/mts_datapath.sv -----
// ----------------------------------------------------------------------------
// Multi-timer scheduler datapath
// Timer table, scaling multiplier, backlog divider, delivery buffer, output.
// ----------------------------------------------------------------------------
`include "multi_timer_scheduler_core_assert.svh"

module mts_datapath #(
  parameter int NUM_TIMERS = mts_pkg::NUM_TIMERS_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  mts_pkg::in_t        req_data,
  input  logic                cfg_valid,
  input  mts_pkg::cfg_t       cfg_data,
  input  mts_pkg::dp_op_t     op,
  output mts_pkg::dp_status_t st,
  output logic                out_valid,
  input  logic                out_ready,
  output mts_pkg::out_t       out_data
);

  localparam int IDX_W     = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;
  localparam int BUF_DEPTH = NUM_TIMERS * mts_pkg::MAX_STEPS;
  localparam int BUF_IW    = $clog2(BUF_DEPTH);
  localparam int BUF_CW    = $clog2(BUF_DEPTH + 1);
  localparam int ACC_W     = mts_pkg::ACC_W;
  localparam logic [3:0]       NUM_T4   = 4'(NUM_TIMERS);
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NUM_TIMERS - 1);

  typedef struct packed {
    logic [2:0]  slot;
    logic [31:0] iteration;
    logic        retired;
  } buf_ent_t;

  // configuration
  logic [15:0] time_scale;
  logic [2:0]  max_steps;

  // timer table
  logic [NUM_TIMERS-1:0] live, paused, unscaled, endless;
  logic [31:0]      period   [NUM_TIMERS];
  logic [31:0]      next_per [NUM_TIMERS];
  logic [ACC_W-1:0] acc      [NUM_TIMERS];
  logic [31:0]      repeats  [NUM_TIMERS];
  logic [31:0]      deliv    [NUM_TIMERS];
  logic [3:0]       live_cnt;
  logic [63:0]      dropped;

  // command and working registers
  mts_pkg::in_t     cmd;
  logic [1:0]       status_r;
  logic [31:0]      q_left;
  logic             q_paused, q_active;
  logic [47:0]      prod;
  logic [IDX_W-1:0] cur;
  logic [ACC_W-1:0] w_acc;
  logic [31:0]      w_next, w_deliv;
  logic [2:0]       steps;

  // divider
  logic [ACC_W-1:0] quo;
  logic [31:0]      rem;
  logic [5:0]       div_cnt;

  // delivery buffer
  buf_ent_t         dbuf [BUF_DEPTH];
  buf_ent_t         buf_q;
  logic [BUF_CW-1:0] wr_cnt, rd_ptr;

  // ---- combinational ----
  logic             in_rng;
  logic [IDX_W-1:0] si;
  logic [31:0]      scaled;
  logic [2:0]       bound;
  logic [ACC_W:0]   acc_sum;
  logic [31:0]      per;
  logic             done_pre, blocked, deliver, done_post;
  logic [31:0]      deliv_n;
  logic [2:0]       steps_n;
  logic [32:0]      trial;
  logic             qbit;
  logic [64:0]      drop_sum;
  logic             out_free, out_load;

  assign in_rng  = 4'(cmd.timer_slot) < NUM_T4;
  assign si      = cmd.timer_slot[IDX_W-1:0];
  assign scaled  = (|prod[47:40]) ? 32'hFFFF_FFFF : prod[39:8];
  assign bound   = (max_steps == 3'd0) ? 3'd1 : max_steps;
  assign acc_sum = {1'b0, acc[cur]} + (ACC_W + 1)'(unscaled[cur] ? cmd.delta : scaled);

  assign per       = w_next;
  assign done_pre  = !endless[cur] && (w_deliv >= repeats[cur]);
  assign blocked   = done_pre || ((per != 32'd0) && (w_acc < ACC_W'(per)));
  assign deliver   = !blocked;
  assign deliv_n   = w_deliv + 32'd1;
  assign done_post = !endless[cur] && (deliv_n >= repeats[cur]);
  assign steps_n   = steps + 3'd1;

  assign trial    = {rem, quo[ACC_W-1]};
  assign qbit     = trial >= {1'b0, w_next};
  assign drop_sum = {1'b0, dropped} + 65'(quo);

  assign out_free = !out_valid || out_ready;
  assign out_load = (op == mts_pkg::OP_EMIT_STATUS) || (op == mts_pkg::OP_EMIT_DELIV) ||
                    (op == mts_pkg::OP_EMIT_FIN);

  always_comb begin
    st.is_advance = (cmd.action == mts_pkg::ACT_ADVANCE);
    st.out_free   = out_free;
    st.slot_run   = live[cur] && !paused[cur];
    st.step_stop  = blocked || done_post || (per == 32'd0) || (steps_n == bound);
    st.need_div   = live[cur] && (steps == bound) && (w_next != 32'd0) &&
                    (w_acc >= ACC_W'(w_next));
    st.div_done   = (div_cnt == 6'(ACC_W - 1));
    st.last_slot  = (cur == LAST_IDX);
    st.buf_empty  = (wr_cnt == '0);
    st.buf_end    = (BUF_CW'(rd_ptr + 1'b1) == wr_cnt);
  end

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      time_scale <= mts_pkg::TIME_SCALE_RST;
      max_steps  <= mts_pkg::MAX_STEPS_RST;
    end else if (cfg_valid) begin
      unique case (cfg_data.index)
        mts_pkg::CFG_TIME_SCALE: time_scale <= cfg_data.value;
        mts_pkg::CFG_MAX_STEPS:  max_steps  <= cfg_data.value[2:0];
        default: ;
      endcase
    end
  end

  // control state of the table
  always_ff @(posedge clk) begin
    if (rst) begin
      live     <= '0;
      paused   <= '0;
      live_cnt <= '0;
      dropped  <= '0;
    end else begin
      unique case (op)
        mts_pkg::OP_EXEC: begin
          unique case (cmd.action)
            mts_pkg::ACT_SCHEDULE: begin
              if ((cmd.repeat_forever || cmd.repeat_count != 32'd0) && in_rng &&
                  !live[si]) begin
                live[si]   <= 1'b1;
                paused[si] <= cmd.paused;
                live_cnt   <= live_cnt + 4'd1;
              end
            end
            mts_pkg::ACT_CANCEL: begin
              if (in_rng && live[si]) begin
                live[si]   <= 1'b0;
                paused[si] <= 1'b0;
                live_cnt   <= live_cnt - 4'd1;
              end
            end
            mts_pkg::ACT_CANCEL_ALL: begin
              live     <= '0;
              paused   <= '0;
              live_cnt <= '0;
            end
            mts_pkg::ACT_SET_PAUSE: begin
              if (in_rng && live[si]) paused[si] <= cmd.paused;
            end
            default: ;
          endcase
        end
        mts_pkg::OP_STEP: begin
          // retire on the final repeat
          if (deliver && done_post) begin
            live[cur]   <= 1'b0;
            paused[cur] <= 1'b0;
            live_cnt    <= live_cnt - 4'd1;
          end
        end
        mts_pkg::OP_DIV_DONE: dropped <= drop_sum[64] ? '1 : drop_sum[63:0];
        default: ;
      endcase
    end
  end

  // payload of the table
  always_ff @(posedge clk) begin
    unique case (op)
      mts_pkg::OP_EXEC: begin
        if (cmd.action == mts_pkg::ACT_SCHEDULE &&
            (cmd.repeat_forever || cmd.repeat_count != 32'd0) && in_rng && !live[si]) begin
          unscaled[si] <= cmd.ignores_scale;
          endless[si]  <= cmd.repeat_forever;
          period[si]   <= cmd.interval;
          next_per[si] <= cmd.delay_given ? cmd.first_delay : cmd.interval;
          acc[si]      <= '0;
          repeats[si]  <= cmd.repeat_count;
          deliv[si]    <= '0;
        end
      end
      mts_pkg::OP_WRITEBACK: begin
        acc[cur]      <= w_acc;
        next_per[cur] <= w_next;
        deliv[cur]    <= w_deliv;
      end
      mts_pkg::OP_DIV_DONE: acc[cur] <= ACC_W'(rem);
      default: ;
    endcase
  end

  // command capture, status, scaling, slot walk and divider
  always_ff @(posedge clk) begin
    unique case (op)
      mts_pkg::OP_CAPTURE: cmd <= req_data;
      mts_pkg::OP_EXEC: begin
        q_left   <= '0;
        q_paused <= 1'b0;
        q_active <= 1'b0;
        unique case (cmd.action)
          mts_pkg::ACT_SCHEDULE: begin
            priority if (!cmd.repeat_forever && cmd.repeat_count == 32'd0)
              status_r <= mts_pkg::ST_BAD_ARG;
            else if (!in_rng) status_r <= mts_pkg::ST_BAD_HANDLE;
            else if (live[si]) status_r <= mts_pkg::ST_SLOT_IN_USE;
            else status_r <= mts_pkg::ST_OK;
          end
          mts_pkg::ACT_CANCEL, mts_pkg::ACT_SET_PAUSE: begin
            status_r <= (in_rng && live[si]) ? mts_pkg::ST_OK : mts_pkg::ST_BAD_HANDLE;
          end
          mts_pkg::ACT_CANCEL_ALL: status_r <= mts_pkg::ST_OK;
          mts_pkg::ACT_QUERY: begin
            if (in_rng && live[si]) begin
              status_r <= mts_pkg::ST_OK;
              q_left   <= (ACC_W'(next_per[si]) > acc[si]) ?
                          32'(ACC_W'(next_per[si]) - acc[si]) : 32'd0;
              q_paused <= paused[si];
              q_active <= 1'b1;
            end else begin
              status_r <= mts_pkg::ST_BAD_HANDLE;
            end
          end
          default: status_r <= mts_pkg::ST_BAD_ARG;
        endcase
      end
      mts_pkg::OP_SCALE: begin
        prod <= 48'(cmd.delta) * 48'(time_scale);
        cur  <= '0;
      end
      mts_pkg::OP_SLOT_LOAD: begin
        w_acc   <= acc_sum[ACC_W] ? '1 : acc_sum[ACC_W-1:0];
        w_next  <= next_per[cur];
        w_deliv <= deliv[cur];
        steps   <= '0;
      end
      mts_pkg::OP_STEP: begin
        if (deliver) begin
          w_acc   <= (per != 32'd0) ? (w_acc - ACC_W'(per)) : '0;
          w_next  <= period[cur];
          w_deliv <= deliv_n;
          steps   <= steps_n;
        end
      end
      mts_pkg::OP_WRITEBACK: begin
        quo     <= w_acc;
        rem     <= '0;
        div_cnt <= '0;
      end
      mts_pkg::OP_DIV_STEP: begin
        // one quotient bit per cycle
        rem     <= qbit ? 32'(trial - {1'b0, w_next}) : trial[31:0];
        quo     <= {quo[ACC_W-2:0], qbit};
        div_cnt <= div_cnt + 6'd1;
      end
      mts_pkg::OP_NEXT_SLOT: begin
        if (cur != LAST_IDX) cur <= cur + 1'b1;
      end
      default: ;
    endcase
  end

  // delivery buffer
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_cnt <= '0;
      rd_ptr <= '0;
    end else if (op == mts_pkg::OP_SCALE) begin
      wr_cnt <= '0;
      rd_ptr <= '0;
    end else if (op == mts_pkg::OP_STEP && deliver) begin
      wr_cnt <= wr_cnt + 1'b1;
    end else if (op == mts_pkg::OP_EMIT_DELIV) begin
      rd_ptr <= rd_ptr + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (op == mts_pkg::OP_STEP && deliver) begin
      dbuf[wr_cnt[BUF_IW-1:0]] <= '{slot: 3'(cur), iteration: deliv_n, retired: done_post};
    end
    buf_q <= dbuf[rd_ptr[BUF_IW-1:0]];
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_data.active_count    <= live_cnt;
      out_data.discarded_total <= dropped;
      out_data.time_left       <= '0;
      out_data.is_paused       <= 1'b0;
      out_data.is_active       <= 1'b0;
      out_data.status          <= mts_pkg::ST_OK;
      out_data.iteration       <= '0;
      out_data.retired         <= 1'b0;
      out_data.slot            <= '0;
      out_data.last            <= 1'b1;
      unique case (op)
        mts_pkg::OP_EMIT_STATUS: begin
          out_data.kind      <= mts_pkg::KIND_STATUS;
          out_data.slot      <= cmd.timer_slot;
          out_data.status    <= status_r;
          out_data.time_left <= q_left;
          out_data.is_paused <= q_paused;
          out_data.is_active <= q_active;
        end
        mts_pkg::OP_EMIT_DELIV: begin
          out_data.kind      <= mts_pkg::KIND_DELIVERY;
          out_data.slot      <= buf_q.slot;
          out_data.iteration <= buf_q.iteration;
          out_data.retired   <= buf_q.retired;
          out_data.last      <= 1'b0;
        end
        default: out_data.kind <= mts_pkg::KIND_FINISHED;
      endcase
    end
  end

  `MTS_ASSERT_IMPL(a_live_count, clk, rst, 1'b1, ($countones(live) == 32'(live_cnt)))
  `MTS_ASSERT_IMPL(a_buf_bound, clk, rst, 1'b1, (32'(wr_cnt) <= BUF_DEPTH))
  `MTS_ASSERT_IMPL(a_emit_free, clk, rst, out_load, out_free)
  `MTS_ASSERT_IMPL(a_rem_below, clk, rst, (op == mts_pkg::OP_DIV_DONE), (rem < w_next))

endmodule

// ----- src/multi_timer_scheduler_core.sv -----
// ----------------------------------------------------------------------------
// Multi-timer scheduler core
// Table of host-addressed timers with scaled advance and bounded catch-up.
// ----------------------------------------------------------------------------
//  channel  dir  payload          transaction
//  req      in   mts_pkg::in_t    one command or advance
//  rsp      out  mts_pkg::out_t   one result; last marks the final one
//  cfg      in   mts_pkg::cfg_t   one register write, always ready
//
// Commands other than advance pass through capture, dispatch, execute and status.
// Advance: capture, dispatch and scale, then per slot load and next, with catch-up
// steps and writeback for a running slot and a radix-2 divide of the 40-bit backlog
// when one is owed, then a read and an emit per delivery and the finished result.
// A stalled rsp holds the core in place; req is taken only between items.
// Synchronous reset clears the live flags and counters and restores the configuration defaults.
// ----------------------------------------------------------------------------
module multi_timer_scheduler_core #(
  parameter int NUM_TIMERS = mts_pkg::NUM_TIMERS_DEF
) (
  input  logic     clk,
  input  logic     rst,
  mts_req_if.sink  req,
  mts_rsp_if.source rsp,
  mts_cfg_if.sink  cfg
);

  mts_pkg::dp_op_t     op;
  mts_pkg::dp_status_t st;

  assign cfg.ready = 1'b1;

  mts_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (req.valid),
    .in_ready (req.ready),
    .st       (st),
    .op       (op)
  );

  mts_datapath #(.NUM_TIMERS(NUM_TIMERS)) u_dp (
    .clk       (clk),
    .rst       (rst),
    .req_data  (req.data),
    .cfg_valid (cfg.valid),
    .cfg_data  (cfg.data),
    .op        (op),
    .st        (st),
    .out_valid (rsp.valid),
    .out_ready (rsp.ready),
    .out_data  (rsp.data)
  );

endmodule

// ----- verif/tb.sv -----
// ----------------------------------------------------------------------------
// Multi-timer scheduler core testbench
// Drives a directed command table and then random command phases through the
// request channel. A local timer-table predictor produces the expected result
// stream. Every result is checked in order, field by field. Configuration is
// rewritten between phases while the core is idle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb;

  localparam int SLOTS     = 8;
  localparam int WDOG_MAX  = 6000;
  localparam int HOLD_LEN  = 400;

  logic clk;
  logic rst;

  mts_req_if req ();
  mts_rsp_if rsp ();
  mts_cfg_if cfg ();

  multi_timer_scheduler_core #(.NUM_TIMERS(SLOTS)) dut (
    .clk (clk),
    .rst (rst),
    .req (req.sink),
    .rsp (rsp.source),
    .cfg (cfg.sink)
  );

  // Predictor state
  bit          t_live [SLOTS];
  bit          t_pause [SLOTS];
  bit          t_raw [SLOTS];
  bit          t_forever [SLOTS];
  logic [31:0] t_period [SLOTS];
  logic [31:0] t_pending [SLOTS];
  logic [39:0] t_acc [SLOTS];
  logic [31:0] t_repeats [SLOTS];
  logic [31:0] t_fired [SLOTS];
  int          live_total;
  logic [63:0] dropped_total;
  logic [15:0] scale_reg;
  logic [2:0]  catchup_reg;

  mts_pkg::out_t expected_q [$];
  int   errors;
  int   mismatches;
  bit   calm;
  bit   hold_req;
  int   idle_cycles;

  typedef struct {
    mts_pkg::in_t cmd;
    bit           typed;
    logic [1:0]   want_status;
  } row_t;

  initial clk = 1'b0;
  always #5 clk = ~clk;

  function automatic mts_pkg::out_t status_item(logic [2:0] s, logic [1:0] st);
    mts_pkg::out_t r;
    r = '0;
    r.kind = mts_pkg::KIND_STATUS;
    r.slot = s;
    r.status = st;
    return r;
  endfunction

  function automatic bit timer_done(int s);
    return !t_forever[s] && t_fired[s] >= t_repeats[s];
  endfunction

  function automatic void release_slot(int s);
    if (t_live[s]) begin
      t_live[s] = 0;
      t_pause[s] = 0;
      if (live_total > 0) live_total--;
    end
  endfunction

  // Apply one command to the timer table; return its first result.
  function automatic mts_pkg::out_t predict_results(mts_pkg::in_t c);
    mts_pkg::out_t res [$];
    mts_pkg::out_t r;
    int          s;
    int          steps;
    int          bound;
    logic [63:0] scaled;
    logic [63:0] a;
    logic [63:0] owed;
    logic [31:0] per;
    bit          done;
    s = c.timer_slot;
    case (c.action)
      mts_pkg::ACT_SCHEDULE: begin
        if (!c.repeat_forever && c.repeat_count == 0)
          res = {res, status_item(c.timer_slot, mts_pkg::ST_BAD_ARG)};
        else if (t_live[s])
          res = {res, status_item(c.timer_slot, mts_pkg::ST_SLOT_IN_USE)};
        else begin
          t_live[s] = 1;
          t_pause[s] = c.paused;
          t_raw[s] = c.ignores_scale;
          t_forever[s] = c.repeat_forever;
          t_period[s] = c.interval;
          t_pending[s] = c.delay_given ? c.first_delay : c.interval;
          t_acc[s] = '0;
          t_repeats[s] = c.repeat_count;
          t_fired[s] = '0;
          live_total++;
          res = {res, status_item(c.timer_slot, mts_pkg::ST_OK)};
        end
      end
      mts_pkg::ACT_CANCEL, mts_pkg::ACT_SET_PAUSE: begin
        if (!t_live[s]) res = {res, status_item(c.timer_slot, mts_pkg::ST_BAD_HANDLE)};
        else begin
          if (c.action == mts_pkg::ACT_CANCEL) release_slot(s);
          else t_pause[s] = c.paused;
          res = {res, status_item(c.timer_slot, mts_pkg::ST_OK)};
        end
      end
      mts_pkg::ACT_CANCEL_ALL: begin
        for (int i = 0; i < SLOTS; i++) release_slot(i);
        res = {res, status_item(c.timer_slot, mts_pkg::ST_OK)};
      end
      mts_pkg::ACT_QUERY: begin
        r = status_item(c.timer_slot, mts_pkg::ST_BAD_HANDLE);
        if (t_live[s]) begin
          r.status = mts_pkg::ST_OK;
          r.time_left = ({8'b0, t_pending[s]} > t_acc[s]) ? t_pending[s] - t_acc[s][31:0] : '0;
          r.is_paused = t_pause[s];
          r.is_active = 1'b1;
        end
        res = {res, r};
      end
      mts_pkg::ACT_ADVANCE: begin
        scaled = ({32'b0, c.delta} * {48'b0, scale_reg}) >> 8;
        if (scaled > 64'hFFFF_FFFF) scaled = 64'hFFFF_FFFF;
        bound = (catchup_reg == 0) ? 1 : catchup_reg;
        for (int i = 0; i < SLOTS; i++) begin
          if (!t_live[i] || t_pause[i]) continue;
          a = {24'b0, t_acc[i]} + (t_raw[i] ? {32'b0, c.delta} : scaled);
          if (a > 64'hFF_FFFF_FFFF) a = 64'hFF_FFFF_FFFF;
          t_acc[i] = a[39:0];
          steps = 0;
          while (steps < bound) begin
            if (timer_done(i)) break;
            per = t_pending[i];
            if (per > 0 && t_acc[i] < {8'b0, per}) break;
            t_acc[i] = (per > 0) ? t_acc[i] - {8'b0, per} : '0;
            t_pending[i] = t_period[i];
            t_fired[i]++;
            steps++;
            done = timer_done(i);
            r = '0;
            r.kind = mts_pkg::KIND_DELIVERY;
            r.slot = 3'(i);
            r.iteration = t_fired[i];
            r.retired = done;
            res = {res, r};
            if (done) begin
              release_slot(i);
              break;
            end
            if (per == 0) break;
          end
          if (!t_live[i] || steps != bound) continue;
          a = {24'b0, t_acc[i]};
          if (t_pending[i] > 0 && a >= {32'b0, t_pending[i]}) begin
            owed = a / {32'b0, t_pending[i]};
            a = a % {32'b0, t_pending[i]};
            t_acc[i] = a[39:0];
            dropped_total = (owed > ~dropped_total) ? '1 : dropped_total + owed;
          end
        end
        r = '0;
        r.kind = mts_pkg::KIND_FINISHED;
        res = {res, r};
      end
      default: res = {res, status_item(c.timer_slot, mts_pkg::ST_BAD_ARG)};
    endcase
    foreach (res[k]) begin
      res[k].active_count = 4'(live_total);
      res[k].discarded_total = dropped_total;
      res[k].last = (k == res.size() - 1);
      expected_q = {expected_q, res[k]};
    end
    return res[0];
  endfunction

  task automatic send_cmd(mts_pkg::in_t c, output mts_pkg::out_t first);
    int gap;
    gap = calm ? 0 : $urandom_range(0, 18);
    if (gap > 0) begin
      req.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req.valid <= 1'b1;
    req.data <= c;
    do @(posedge clk); while (!req.ready);
    first = predict_results(c);
  endtask

  task automatic write_reg(logic [mts_pkg::CFG_IDX_W-1:0] idx, logic [15:0] val);
    req.valid <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    cfg.valid <= 1'b1;
    cfg.data <= '{index: idx, value: val};
    do @(posedge clk); while (!cfg.ready);
    cfg.valid <= 1'b0;
    if (idx == mts_pkg::CFG_TIME_SCALE) scale_reg = val;
    else catchup_reg = val[2:0];
    @(posedge clk);
  endtask

  function automatic logic [31:0] pick32(int lim);
    int sel;
    sel = $urandom_range(0, 15);
    if (sel == 0) return 32'hFFFF_FFFF;
    if (sel < 3) return $urandom;
    return $urandom_range(0, lim);
  endfunction

  function automatic mts_pkg::in_t random_cmd();
    mts_pkg::in_t c;
    int  sel;
    c = '0;
    sel = $urandom_range(0, 99);
    if (sel < 30) c.action = mts_pkg::ACT_SCHEDULE;
    else if (sel < 60) c.action = mts_pkg::ACT_ADVANCE;
    else if (sel < 72) c.action = mts_pkg::ACT_QUERY;
    else if (sel < 82) c.action = mts_pkg::ACT_SET_PAUSE;
    else if (sel < 92) c.action = mts_pkg::ACT_CANCEL;
    else if (sel < 95) c.action = mts_pkg::ACT_CANCEL_ALL;
    else c.action = 3'($urandom_range(6, 7));
    c.timer_slot = 3'($urandom_range(0, 7));
    c.interval = pick32(300);
    c.first_delay = pick32(300);
    c.delay_given = 1'($urandom_range(0, 1));
    c.repeat_count = ($urandom_range(0, 9) == 0) ? 32'd0 : pick32(6);
    c.repeat_forever = ($urandom_range(0, 3) == 0);
    c.ignores_scale = 1'($urandom_range(0, 1));
    c.paused = ($urandom_range(0, 4) == 0);
    c.delta = pick32(600);
    return c;
  endfunction

  function automatic mts_pkg::in_t mk(logic [2:0] act, logic [2:0] s, logic [31:0] ivl,
                                      logic [31:0] fd, bit dg, logic [31:0] rc, bit fv,
                                      bit raw, bit pz, logic [31:0] d);
    mts_pkg::in_t c;
    c = '{act, s, ivl, fd, dg, rc, fv, raw, pz, d};
    return c;
  endfunction

  // Receiver: random stalls, one long hold-off on request
  initial begin
    int stall;
    rsp.ready = 1'b0;
    @(negedge rst);
    forever begin
      if (hold_req) begin
        hold_req = 0;
        rsp.ready <= 1'b0;
        repeat (HOLD_LEN) @(posedge clk);
      end else begin
        stall = calm ? 0 : $urandom_range(0, 18);
        if (stall > 0) begin
          rsp.ready <= 1'b0;
          repeat (stall) @(posedge clk);
        end
      end
      rsp.ready <= 1'b1;
      do @(posedge clk); while (!rsp.valid);
      if (expected_q.size() == 0) begin
        errors++;
        if (mismatches++ < 10) $display("unexpected result: %p", rsp.data);
      end else begin
        mts_pkg::out_t want;
        mts_pkg::out_t got;
        want = expected_q.pop_front();
        got = rsp.data;
        if (got.kind !== want.kind || got.slot !== want.slot ||
            got.iteration !== want.iteration || got.retired !== want.retired ||
            got.status !== want.status || got.time_left !== want.time_left ||
            got.is_paused !== want.is_paused || got.is_active !== want.is_active ||
            got.active_count !== want.active_count ||
            got.discarded_total !== want.discarded_total || got.last !== want.last) begin
          errors++;
          if (mismatches++ < 10) $display("mismatch: expected %p got %p", want, got);
        end
      end
    end
  end

  // Watchdog on cycles with no transaction on any channel
  always @(posedge clk) begin
    if (rst || (req.valid && req.ready) || (rsp.valid && rsp.ready) ||
        (cfg.valid && cfg.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WDOG_MAX) begin
      $display("multi_timer_scheduler_core test failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    row_t table_rows [$];
    mts_pkg::out_t first;
    rst = 1'b1;
    req.valid = 1'b0;
    req.data = '0;
    cfg.valid = 1'b0;
    cfg.data = '0;
    errors = 0;
    mismatches = 0;
    calm = 0;
    hold_req = 0;
    live_total = 0;
    dropped_total = '0;
    scale_reg = mts_pkg::TIME_SCALE_RST;
    catchup_reg = mts_pkg::MAX_STEPS_RST;
    foreach (t_live[i]) begin
      t_live[i] = 0;
      t_pause[i] = 0;
    end
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    table_rows = '{
      '{mk(mts_pkg::ACT_QUERY, 0, 0, 0, 0, 0, 0, 0, 0, 0), 1, mts_pkg::ST_BAD_HANDLE},
      '{mk(mts_pkg::ACT_CANCEL, 3, 0, 0, 0, 0, 0, 0, 0, 0), 1, mts_pkg::ST_BAD_HANDLE},
      '{mk(mts_pkg::ACT_SET_PAUSE, 5, 0, 0, 0, 0, 0, 0, 1, 0), 1, mts_pkg::ST_BAD_HANDLE},
      '{mk(mts_pkg::ACT_SCHEDULE, 2, 10, 0, 0, 0, 0, 0, 0, 0), 1, mts_pkg::ST_BAD_ARG},
      '{mk(3'd6, 4, 0, 0, 0, 0, 0, 0, 0, 0), 1, mts_pkg::ST_BAD_ARG},
      '{mk(3'd7, 6, '1, '1, 1, '1, 1, 1, 1, '1), 1, mts_pkg::ST_BAD_ARG},
      '{mk(mts_pkg::ACT_SCHEDULE, 0, 10, 0, 0, 3, 0, 0, 0, 0), 1, mts_pkg::ST_OK},
      '{mk(mts_pkg::ACT_SCHEDULE, 0, 10, 0, 0, 3, 0, 0, 0, 0), 1, mts_pkg::ST_SLOT_IN_USE},
      '{mk(mts_pkg::ACT_SCHEDULE, 7, 0, 0, 0, 0, 1, 1, 0, 0), 1, mts_pkg::ST_OK},
      '{mk(mts_pkg::ACT_SCHEDULE, 1, 100, '1, 1, '1, 0, 0, 1, 0), 1, mts_pkg::ST_OK},
      '{mk(mts_pkg::ACT_SCHEDULE, 2, 1, 0, 1, 2, 0, 1, 0, 0), 1, mts_pkg::ST_OK},
      '{mk(mts_pkg::ACT_SCHEDULE, 3, 7, 5, 1, 0, 1, 0, 0, 0), 1, mts_pkg::ST_OK},
      '{mk(mts_pkg::ACT_QUERY, 1, 0, 0, 0, 0, 0, 0, 0, 0), 0, mts_pkg::ST_OK},
      '{mk(mts_pkg::ACT_ADVANCE, 0, 0, 0, 0, 0, 0, 0, 0, 25), 0, mts_pkg::ST_OK},
      '{mk(mts_pkg::ACT_ADVANCE, 0, 0, 0, 0, 0, 0, 0, 0, '1), 0, mts_pkg::ST_OK},
      '{mk(mts_pkg::ACT_SET_PAUSE, 1, 0, 0, 0, 0, 0, 0, 0, 0), 1, mts_pkg::ST_OK},
      '{mk(mts_pkg::ACT_ADVANCE, 0, 0, 0, 0, 0, 0, 0, 0, 1000), 0, mts_pkg::ST_OK},
      '{mk(mts_pkg::ACT_QUERY, 3, 0, 0, 0, 0, 0, 0, 0, 0), 0, mts_pkg::ST_OK},
      '{mk(mts_pkg::ACT_QUERY, 7, 0, 0, 0, 0, 0, 0, 0, 0), 0, mts_pkg::ST_OK},
      '{mk(mts_pkg::ACT_CANCEL, 7, 0, 0, 0, 0, 0, 0, 0, 0), 1, mts_pkg::ST_OK},
      '{mk(mts_pkg::ACT_CANCEL_ALL, 5, 0, 0, 0, 0, 0, 0, 0, 0), 1, mts_pkg::ST_OK},
      '{mk(mts_pkg::ACT_ADVANCE, 0, 0, 0, 0, 0, 0, 0, 0, 0), 0, mts_pkg::ST_OK}
    };
    foreach (table_rows[i]) begin
      send_cmd(table_rows[i].cmd, first);
      if (table_rows[i].typed && first.status !== table_rows[i].want_status) begin
        errors++;
        $display("row %0d: status %0d, table says %0d", i, first.status,
                 table_rows[i].want_status);
      end
    end

    // Random phases; the first two use the register extremes
    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        0: begin
          write_reg(mts_pkg::CFG_TIME_SCALE, 16'd0);
          write_reg(mts_pkg::CFG_MAX_STEPS, 16'd0);
        end
        1: begin
          write_reg(mts_pkg::CFG_TIME_SCALE, 16'hFFFF);
          write_reg(mts_pkg::CFG_MAX_STEPS, 16'd7);
        end
        default: begin
          write_reg(mts_pkg::CFG_TIME_SCALE,
                    ($urandom_range(0, 2) == 0) ? 16'($urandom) : 16'd256);
          write_reg(mts_pkg::CFG_MAX_STEPS, 16'($urandom_range(1, 7)));
        end
      endcase
      if (ph == 2) hold_req = 1;
      for (int n = 0; n < 85; n++) begin
        if ($urandom_range(0, 29) == 0) calm = ~calm;
        send_cmd(random_cmd(), first);
      end
      calm = 0;
    end
    req.valid <= 1'b0;

    while (expected_q.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);
    if (errors == 0) begin
      $display("multi_timer_scheduler_core test passed");
    end else begin
      $display("multi_timer_scheduler_core test failed");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
+incdir+src
src/mts_pkg.sv
src/mts_channels.sv
src/mts_ctrl.sv
src/mts_datapath.sv
src/multi_timer_scheduler_core.sv
verif/tb.sv
